// ----- rtl/core/dmaf_pkg.sv -----
// Shared constants, types and state codes for the dual moving-average filter.
package dmaf_pkg;

    localparam int WINDOW  = 8;
    localparam int SPEED_W = 16;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = SPEED_W + SLOT_W;
    localparam int DIV_W   = $clog2(WINDOW + 1);
    localparam int REM_W   = DIV_W + 1;
    localparam int CNT_W   = $clog2(TOTAL_W);
    localparam int LANES   = 2;

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic [TOTAL_W-1:0]        t_total;
    typedef logic [SLOT_W-1:0]         t_slot;
    typedef logic [DIV_W-1:0]          t_div;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/dual_moving_average_filter_core.sv -----
// Top level of the dual moving-average filter: bit-serial totals and divider.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_left_speed, i_right_speed
//  output    out        o_out_valid / i_out_stall o_left_mean, o_right_mean
//
// A request is accepted in idle, then takes TOTAL_W serial steps that update
// both running totals one bit a cycle, a step that takes magnitudes, TOTAL_W
// restoring-division steps, and a final state that loads the result.
// Synchronous active-low reset clears the rings, totals, slot and fill flag.
// A finished result waits in the output register while the next request is
// taken; a new result waits in the last state while the output is stalled.
module dual_moving_average_filter_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dmaf_pkg::t_speed      i_left_speed,
    input  dmaf_pkg::t_speed      i_right_speed,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dmaf_pkg::t_speed      o_left_mean,
    output dmaf_pkg::t_speed      o_right_mean
);
    import dmaf_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_last;
    logic             w_accept;
    logic             w_out_free;

    t_speed r_ring [LANES][WINDOW];
    t_slot  r_slot;
    logic   r_filled;
    t_div   r_div;

    t_total r_tot [LANES];
    t_speed r_new [LANES];
    t_speed r_old [LANES];
    logic   r_ca  [LANES];
    logic   r_cb  [LANES];
    t_total r_dvd [LANES];
    t_div   r_rem [LANES];
    logic   r_neg [LANES];
    t_speed r_mean [LANES];
    logic   r_out_valid;

    logic       w_s1 [LANES];
    logic       w_s2 [LANES];
    logic       w_ca [LANES];
    logic       w_cb [LANES];
    logic       w_nold [LANES];
    logic [REM_W-1:0] w_trial [LANES];
    logic       w_qbit [LANES];
    t_speed     w_in [LANES];

    assign w_in[0]    = i_left_speed;
    assign w_in[1]    = i_right_speed;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_cnt == CNT_W'(TOTAL_W - 1));

    // One full-adder pair and one divide step per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_nold[l] = ~r_old[l][0];
            w_s1[l]   = r_tot[l][0] ^ r_new[l][0] ^ r_ca[l];
            w_ca[l]   = (r_tot[l][0] & r_new[l][0]) | (r_tot[l][0] & r_ca[l])
                      | (r_new[l][0] & r_ca[l]);
            w_s2[l]   = w_s1[l] ^ w_nold[l] ^ r_cb[l];
            w_cb[l]   = (w_s1[l] & w_nold[l]) | (w_s1[l] & r_cb[l])
                      | (w_nold[l] & r_cb[l]);
            w_trial[l] = {r_rem[l], r_dvd[l][TOTAL_W-1]};
            w_qbit[l]  = (w_trial[l] >= {1'b0, r_div});
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_SUM;
            end
            S_SUM: if (w_last) begin
                n_state = S_PREP;
            end
            S_PREP: n_state = S_DIV;
            S_DIV: if (w_last) begin
                n_state = S_DONE;
            end
            S_DONE: if (w_out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Bit counter for the serial phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if ((r_state == S_SUM || r_state == S_DIV) && !w_last) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    // Write the rings and advance the slot on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                for (int e = 0; e < WINDOW; e++) begin
                    r_ring[l][e] <= '0;
                end
            end
            r_slot   <= '0;
            r_filled <= 1'b0;
        end else if (w_accept) begin
            for (int l = 0; l < LANES; l++) begin
                r_ring[l][r_slot] <= w_in[l];
            end
            if (r_slot == SLOT_W'(WINDOW - 1)) begin
                r_slot   <= '0;
                r_filled <= 1'b1;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Running totals: rotate total + new - old one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_tot[l] <= '0;
            end
        end else if (r_state == S_SUM) begin
            for (int l = 0; l < LANES; l++) begin
                r_tot[l] <= {w_s2[l], r_tot[l][TOTAL_W-1:1]};
            end
        end
    end

    // Operand shift registers and carries
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int l = 0; l < LANES; l++) begin
                r_new[l] <= w_in[l];
                r_old[l] <= r_ring[l][r_slot];
                r_ca[l]  <= 1'b0;
                r_cb[l]  <= 1'b1;
            end
        end else if (r_state == S_SUM) begin
            for (int l = 0; l < LANES; l++) begin
                r_new[l] <= {r_new[l][SPEED_W-1], r_new[l][SPEED_W-1:1]};
                r_old[l] <= {r_old[l][SPEED_W-1], r_old[l][SPEED_W-1:1]};
                r_ca[l]  <= w_ca[l];
                r_cb[l]  <= w_cb[l];
            end
        end
    end

    // Divider: take magnitudes, then one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_div <= r_filled ? DIV_W'(WINDOW) : DIV_W'(r_slot);
            for (int l = 0; l < LANES; l++) begin
                r_neg[l] <= r_tot[l][TOTAL_W-1];
                r_dvd[l] <= r_tot[l][TOTAL_W-1] ? (~r_tot[l] + 1'b1) : r_tot[l];
                r_rem[l] <= '0;
            end
        end else if (r_state == S_DIV) begin
            for (int l = 0; l < LANES; l++) begin
                r_dvd[l] <= {r_dvd[l][TOTAL_W-2:0], w_qbit[l]};
                r_rem[l] <= w_qbit[l] ? DIV_W'(w_trial[l] - {1'b0, r_div})
                                      : DIV_W'(w_trial[l]);
            end
        end
    end

    // Load the output register with signed quotients
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            for (int l = 0; l < LANES; l++) begin
                r_mean[l] <= r_neg[l] ? SPEED_W'(~r_dvd[l] + 1'b1)
                                      : SPEED_W'(r_dvd[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_left_mean  = r_mean[0];
    assign o_right_mean = r_mean[1];

    // An accepted request always starts the serial update
    a_accept_starts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SUM))
        else $error("accepted request did not start the total update");

    // The divisor stays between one and the window length
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0 && r_div <= DIV_W'(WINDOW)))
        else $error("divisor out of range");

    // A new result appears only out of the final state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the final state");

    // The write slot never leaves the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond ring");

endmodule
